// ----- rtl/core/bpfb_pkg.sv -----
// shared constants, types and lookup tables of the bit-plane led frame buffer
package bpfb_pkg;

    // matrix geometry
    localparam int COLS   = 16;
    localparam int ROWS   = 16;
    localparam int PLANES = 3;

    // derived sizes
    localparam int DEPTH = PLANES * ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(COLS);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW    = $clog2(PLANES + 1);

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_SHIFT = 2'd2;
    localparam logic [1:0] CMD_GET   = 2'd3;

    typedef logic [CW-1:0] col_lut_t [256];
    typedef logic [RW-1:0] row_lut_t [256];

    // coordinate wrap tables, built with a wrapping counter
    function automatic col_lut_t build_col_lut();
        col_lut_t t;
        int c;
        c = 0;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = CW'(c);
            c = c + 1;
            if (c == COLS)
                c = 0;
        end
        return t;
    endfunction

    function automatic row_lut_t build_row_lut();
        row_lut_t t;
        int r;
        r = 0;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = RW'(r);
            r = r + 1;
            if (r == ROWS)
                r = 0;
        end
        return t;
    endfunction

    localparam col_lut_t COL_LUT = build_col_lut();
    localparam row_lut_t ROW_LUT = build_row_lut();

endpackage

// ----- rtl/core/bpfb_ram.sv -----
// generic simple dual-port ram with registered read
module bpfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/bit_plane_led_frame_buffer.sv -----
// top level of the bit-plane led frame buffer
//
// Usage: present command, x_coord, y_coord and level with start high; the
// transfer happens at a rising edge where start is high and busy is low.
// Every command produces exactly one result: done is high for one cycle with
// pixel_lit and out_of_range valid in that cycle. The receiver cannot stall,
// so done is a plain one-cycle strobe and is never held.
// The frame store is one ram of PLANES*ROWS rows by COLS bits, one row per
// plane and matrix row; every command works through its single read and
// single write port. Steps of each command from transfer to done:
//   clear : one row written per cycle
//   set   : read then write back per plane
//   shift : read and write pipelined one row apart
//   get   : one plane-0 row read
// busy stays high from the transfer until done; a new command may be taken
// in the cycle in which done is high.
// Reset clears one valid flag per store row at once; a row whose flag is
// clear reads as all dark, so no clearing pass follows reset.
module bit_plane_led_frame_buffer
    import bpfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] x_coord,
    input  logic [7:0] y_coord,
    input  logic [7:0] level,
    output logic       done,
    output logic       pixel_lit,
    output logic       out_of_range
);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CLEAR   = 3'd1;
    localparam logic [2:0] ST_SET_RD  = 3'd2;
    localparam logic [2:0] ST_SET_WR  = 3'd3;
    localparam logic [2:0] ST_SHIFT   = 3'd4;
    localparam logic [2:0] ST_GET_RD  = 3'd5;
    localparam logic [2:0] ST_GET_OUT = 3'd6;

    localparam logic [AW-1:0]   ROWS_A    = AW'(ROWS);
    localparam logic [CNTW-1:0] DEPTH_C   = CNTW'(DEPTH);
    localparam logic [CNTW-1:0] LAST_C    = CNTW'(DEPTH - 1);
    localparam logic [RW-1:0]   LAST_ROW  = RW'(ROWS - 1);
    localparam logic [PW-1:0]   PLANES_P  = PW'(PLANES);
    localparam logic [PW-1:0]   LAST_PL   = PW'(PLANES - 1);
    localparam logic [7:0]      COLS_B    = 8'(COLS);
    localparam logic [7:0]      ROWS_B    = 8'(ROWS);

    logic [2:0]       state_reg, state_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [RW-1:0]    row_cnt_reg, row_cnt_next;
    logic [PW-1:0]    plane_reg, plane_next;
    logic [PW-1:0]    lit_lvl_reg, lit_lvl_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [AW-1:0]    wr_addr_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [7:0]       x_reg, x_next;
    logic [7:0]       y_reg, y_next;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic             done_reg, done_next;
    logic             lit_reg, lit_next;
    logic             oor_reg, oor_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [COLS-1:0]  ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [COLS-1:0]  ram_rdata;
    logic [COLS-1:0]  row_data;
    logic [COLS-1:0]  set_data;
    logic             get_oor;
    logic             accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // row as stored, dark when never written since reset
    assign row_data = rd_valid_reg ? ram_rdata : '0;

    // set: force the pixel bit for the current plane
    always_comb
    begin
        set_data          = row_data;
        set_data[col_reg] = (plane_reg < lit_lvl_reg);
    end

    assign get_oor = (x_reg >= COLS_B) || (y_reg >= ROWS_B);

    // frame store
    bpfb_ram #(
        .WIDTH (COLS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer and memory port control
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        row_cnt_next = row_cnt_reg;
        plane_next   = plane_reg;
        lit_lvl_next = lit_lvl_reg;
        addr_next    = addr_reg;
        col_next     = col_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        done_next    = 1'b0;
        lit_next     = 1'b0;
        oor_next     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = set_data;
        ram_raddr    = addr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next       = x_coord;
                    y_next       = y_coord;
                    col_next     = COL_LUT[x_coord];
                    addr_next    = AW'(ROW_LUT[y_coord]);
                    lit_lvl_next = (level > 8'(PLANES)) ? PLANES_P : PW'(level);
                    cnt_next     = '0;
                    row_cnt_next = '0;
                    plane_next   = '0;
                    case (command)
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_SET:   state_next = ST_SET_RD;
                        CMD_SHIFT: state_next = ST_SHIFT;
                        CMD_GET:   state_next = ST_GET_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end

            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = (plane_reg < lit_lvl_reg) ? '1 : '0;
                cnt_next  = cnt_reg + 1'b1;
                if (row_cnt_reg == LAST_ROW)
                begin
                    row_cnt_next = '0;
                    plane_next   = plane_reg + 1'b1;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
                if (cnt_reg == LAST_C)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end

            ST_SET_RD:
            begin
                ram_raddr  = addr_reg;
                state_next = ST_SET_WR;
            end

            ST_SET_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = set_data;
                if (plane_reg == LAST_PL)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                    addr_next  = addr_reg + ROWS_A;
                    state_next = ST_SET_RD;
                end
            end

            ST_SHIFT:
            begin
                // read row k while writing row k-1 back shifted
                ram_raddr = (cnt_reg < DEPTH_C) ? cnt_reg[AW-1:0] : '0;
                ram_we    = (cnt_reg != '0);
                ram_waddr = wr_addr_reg;
                ram_wdata = row_data >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DEPTH_C)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end

            ST_GET_RD:
            begin
                ram_raddr  = get_oor ? '0 : AW'(y_reg);
                state_next = ST_GET_OUT;
            end

            ST_GET_OUT:
            begin
                oor_next   = get_oor;
                lit_next   = get_oor ? 1'b0 : row_data[x_reg[CW-1:0]];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
            lit_reg   <= 1'b0;
            oor_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            lit_reg   <= lit_next;
            oor_reg   <= oor_next;
            if (ram_we)
                valid_reg[ram_waddr] <= 1'b1;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        row_cnt_reg  <= row_cnt_next;
        plane_reg    <= plane_next;
        lit_lvl_reg  <= lit_lvl_next;
        addr_reg     <= addr_next;
        col_reg      <= col_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        wr_addr_reg  <= ram_raddr;
        rd_valid_reg <= valid_reg[ram_raddr];
    end

    assign done         = done_reg;
    assign pixel_lit    = lit_reg;
    assign out_of_range = oor_reg;

    // every transfer starts a command
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("command transfer did not start the sequencer");

    // a command ends only with its result
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("sequencer went idle without a result");

    // results appear only when idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // flags come only with a result, and out of range never lights a pixel
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_lit || out_of_range) |-> (done && !(pixel_lit && out_of_range)))
        else $error("result flags outside a result or both set");

endmodule

// ----- verif/bit_plane_led_frame_buffer_check.sv -----
`timescale 1ns / 1ps
// result checker for the bit-plane led frame buffer: mirrors the frame store and compares results
module bit_plane_led_frame_buffer_check
    import bpfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] x_coord,
    input  logic [7:0] y_coord,
    input  logic [7:0] level,
    input  logic       done,
    input  logic       pixel_lit,
    input  logic       out_of_range,
    output int         failures,
    output int         pending
);

    localparam int MAX_PRINTED = 100;

    typedef logic [COLS-1:0] plane_row_t;

    // one outstanding result with the command that caused it
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic       lit;
        logic       oor;
    } pixel_read_t;

    plane_row_t  mirror_planes [PLANES][ROWS];
    pixel_read_t pixel_reads [$];

    initial
    begin
        failures = 0;
    end

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= MAX_PRINTED)
            $display("%0t ns mismatch: %s", $realtime, what);
    endtask

    // apply one command to the mirrored planes and return its result
    function automatic pixel_read_t run_command(input logic [1:0] cmd, input logic [7:0] x,
                                                input logic [7:0] y, input logic [7:0] lvl);
        pixel_read_t r;
        int          col;
        int          row;
        int          lit_planes;
        r.cmd = cmd;
        r.x   = x;
        r.y   = y;
        r.lit = 1'b0;
        r.oor = 1'b0;
        col = int'(x) % COLS;
        row = int'(y) % ROWS;
        lit_planes = (int'(lvl) > PLANES) ? PLANES : int'(lvl);
        case (cmd)
            CMD_CLEAR:
            begin
                for (int p = 0; p < PLANES; p++)
                    for (int q = 0; q < ROWS; q++)
                        mirror_planes[p][q] = (p < lit_planes) ? {COLS{1'b1}} : {COLS{1'b0}};
            end
            CMD_SET:
            begin
                // thermometer code: lit in planes below the saturated level
                for (int p = 0; p < PLANES; p++)
                    mirror_planes[p][row][col] = (p < lit_planes);
            end
            CMD_SHIFT:
            begin
                // toward column zero, zero enters the last column
                for (int p = 0; p < PLANES; p++)
                    for (int q = 0; q < ROWS; q++)
                        mirror_planes[p][q] = mirror_planes[p][q] >> 1;
            end
            CMD_GET:
            begin
                // no wrap on reads
                if (int'(x) >= COLS || int'(y) >= ROWS)
                    r.oor = 1'b1;
                else
                    r.lit = mirror_planes[0][row][col];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_read_t want;
        if (!rst_n)
        begin
            for (int p = 0; p < PLANES; p++)
                for (int q = 0; q < ROWS; q++)
                    mirror_planes[p][q] = '0;
            pixel_reads.delete();
            pending <= 0;
        end
        else
        begin
            // result transfer against the oldest outstanding command
            if (done)
            begin
                if (pixel_reads.size() == 0)
                    report_mismatch("result strobe with no command outstanding");
                else
                begin
                    want = pixel_reads.pop_front();
                    if (pixel_lit !== want.lit)
                        report_mismatch($sformatf("pixel_lit %b, want %b (cmd %0d x %0d y %0d)",
                                                  pixel_lit, want.lit, want.cmd, want.x, want.y));
                    if (out_of_range !== want.oor)
                        report_mismatch($sformatf("out_of_range %b, want %b (cmd %0d x %0d y %0d)",
                                                  out_of_range, want.oor, want.cmd, want.x,
                                                  want.y));
                end
            end
            // command transfer, may share the edge with a result
            if (start && !busy)
                pixel_reads.push_back(run_command(command, x_coord, y_coord, level));
            pending <= pixel_reads.size();
        end
    end

endmodule

// ----- verif/bit_plane_led_frame_buffer_test.sv -----
`timescale 1ns / 1ps
// testbench top for the bit-plane led frame buffer: clock, reset, commands and verdict
module bit_plane_led_frame_buffer_test;
    import bpfb_pkg::*;

    localparam int RANDOM_COMMANDS = 1550;
    localparam int PHASES          = 4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 64;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] command;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [7:0] level;
    logic       done;
    logic       pixel_lit;
    logic       out_of_range;
    int         failures;
    int         pending;
    int         cycle_count;
    logic [7:0] last_x;
    logic [7:0] last_y;

    bit_plane_led_frame_buffer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .level        (level),
        .done         (done),
        .pixel_lit    (pixel_lit),
        .out_of_range (out_of_range)
    );

    bit_plane_led_frame_buffer_check result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .level        (level),
        .done         (done),
        .pixel_lit    (pixel_lit),
        .out_of_range (out_of_range),
        .failures     (failures),
        .pending      (pending)
    );

    always #6 clk = ~clk;

    // one command transfer, after a random number of idle cycles
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] x,
                                input logic [7:0] y, input logic [7:0] lvl,
                                input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        x_coord <= x;
        y_coord <= y;
        level   <= lvl;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random command, mostly on the matrix and often reading back the last pixel written
    task automatic send_random(input int idle_pct);
        int         pick;
        logic [1:0] cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] lvl;
        pick = $urandom_range(99);
        if (pick < 10)
            cmd = CMD_CLEAR;
        else if (pick < 22)
            cmd = CMD_SHIFT;
        else if (pick < 58)
            cmd = CMD_SET;
        else
            cmd = CMD_GET;
        if ($urandom_range(4) == 0)
        begin
            x = 8'($urandom_range(255));
            y = 8'($urandom_range(255));
        end
        else
        begin
            x = 8'($urandom_range(COLS - 1));
            y = 8'($urandom_range(ROWS - 1));
        end
        if (cmd == CMD_GET && $urandom_range(1) == 0)
        begin
            x = last_x;
            y = last_y;
        end
        if ($urandom_range(3) == 0)
            lvl = 8'($urandom_range(255));
        else
            lvl = 8'($urandom_range(PLANES + 1));
        // follow the last written pixel through wraps and shifts
        if (cmd == CMD_SET)
        begin
            last_x = 8'(x % COLS);
            last_y = 8'(y % ROWS);
        end
        else if (cmd == CMD_SHIFT && last_x != 8'd0)
            last_x = last_x - 8'd1;
        send_command(cmd, x, y, lvl, idle_pct);
    endtask

    initial
    begin
        int phase_idle [PHASES];
        // sender idle percentages; the receiver stall phase runs gap-free
        // since done cannot be held back
        phase_idle[0] = 0;
        phase_idle[1] = 74;
        phase_idle[2] = 0;
        phase_idle[3] = 7;
        rst_n   = 1'b0;
        start   = 1'b0;
        command = CMD_CLEAR;
        x_coord = '0;
        y_coord = '0;
        level   = '0;
        last_x  = '0;
        last_y  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads after reset, corners and off-matrix reads
        send_command(CMD_GET, 8'd0, 8'd0, 8'd0, 0);
        send_command(CMD_GET, 8'd15, 8'd15, 8'd255, 0);
        send_command(CMD_GET, 8'd16, 8'd0, 8'd0, 0);
        send_command(CMD_GET, 8'd0, 8'd16, 8'd0, 0);
        send_command(CMD_GET, 8'd255, 8'd255, 8'd0, 0);
        // fill plane zero, then shift a zero into the last column
        send_command(CMD_CLEAR, 8'd0, 8'd0, 8'd1, 0);
        send_command(CMD_GET, 8'd15, 8'd15, 8'd0, 0);
        send_command(CMD_SHIFT, 8'd255, 8'd255, 8'd255, 0);
        send_command(CMD_GET, 8'd15, 8'd3, 8'd0, 0);
        send_command(CMD_GET, 8'd14, 8'd3, 8'd0, 0);
        // set with wrapped coordinates and saturated level, then darken it
        send_command(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 0);
        send_command(CMD_SET, 8'd255, 8'd255, 8'd255, 0);
        send_command(CMD_GET, 8'd15, 8'd15, 8'd0, 0);
        send_command(CMD_SET, 8'd15, 8'd15, 8'd0, 0);
        send_command(CMD_GET, 8'd15, 8'd15, 8'd0, 0);
        // column zero drops out on shift
        send_command(CMD_SET, 8'd128, 8'd16, 8'd2, 0);
        send_command(CMD_GET, 8'd0, 8'd0, 8'd0, 0);
        send_command(CMD_SHIFT, 8'd0, 8'd0, 8'd0, 0);
        send_command(CMD_GET, 8'd0, 8'd0, 8'd0, 0);
        // full and over-range clear levels
        send_command(CMD_CLEAR, 8'd0, 8'd0, 8'd3, 0);
        send_command(CMD_CLEAR, 8'd0, 8'd0, 8'd255, 0);
        send_command(CMD_SET, 8'd17, 8'd33, 8'd1, 0);
        send_command(CMD_SHIFT, 8'd0, 8'd0, 8'd0, 0);
        send_command(CMD_GET, 8'd0, 8'd1, 8'd0, 0);
        send_command(CMD_GET, 8'd7, 8'd128, 8'd0, 0);

        for (int phase = 0; phase < PHASES; phase++)
            repeat (RANDOM_COMMANDS / PHASES) send_random(phase_idle[phase]);
        start <= 1'b0;

        // drain, then give a late or extra strobe time to show up
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        // a result still outstanding here was lost
        if (failures == 0 && pending == 0)
            $display("** bit_plane_led_frame_buffer: PASSED **");
        else
            $display("** bit_plane_led_frame_buffer: FAILED **");
        $finish;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("** bit_plane_led_frame_buffer: FAILED **");
        $finish;
    end

endmodule
